// ===== src/asc_pkg.sv =====
// Shared types, register indexes and command codes of the accelerometer sample conditioner.
package asc_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 21;

   localparam logic [CsrIndexWidth-1:0] REG_SCALE    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_OFFSET_X = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_OFFSET_Y = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_OFFSET_Z = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_GAIN_X   = 3'd4;
   localparam logic [CsrIndexWidth-1:0] REG_GAIN_Y   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] REG_GAIN_Z   = 3'd6;

   localparam logic [15:0] SCALE_RESET = 16'd4096;
   localparam logic [17:0] GAIN_RESET  = 18'd65536;

   localparam logic [1:0] AXIS_LAST = 2'd2;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_RAW,
      OP_SCALE,
      OP_ADDV,
      OP_DIV5,
      OP_FILT,
      OP_ACC,
      OP_MUL_GAIN,
      OP_SAT,
      OP_MUL_SQ,
      OP_SUM_SQ,
      OP_SQRT,
      OP_DIVU,
      OP_UNIT,
      OP_OUT
   } dp_op_type;

   typedef enum logic {
      DIV_FIVE,
      DIV_UNIT
   } div_mode_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] axis;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic sqrt_busy;
      logic sq_zero;
      logic out_free;
   } sts_type;

endpackage

// ===== src/asc_divider.sv =====
// Shared divider: seven quotient bits a cycle for the filter's division by five, one for the unit vector.
module asc_divider
   import asc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  div_mode_type mode,
   input  logic [47:0]  dividend,
   input  logic [31:0]  divisor,
   output logic         busy,
   output logic [33:0]  quotient
);

   logic         busy_ff, busy_in;
   div_mode_type mode_ff, mode_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [31:0]  rem_ff, rem_in;
   logic [47:0]  sh_ff, sh_in;
   logic [33:0]  quot_ff, quot_in;
   logic [31:0]  dsr_ff, dsr_in;
   logic [32:0]  trial;
   logic         fits;
   logic [9:0]   five_part;
   logic [17:0]  five_prod;
   logic [6:0]   five_digit;
   logic [9:0]   five_back;

   always_comb begin
      trial      = {rem_ff, sh_ff[47]};
      fits       = trial >= {1'b0, dsr_ff};
      // Remainder below five and seven new bits stay below 1024, where multiplying by
      // 205 and dropping ten bits gives the exact quotient by five.
      five_part  = {rem_ff[2:0], sh_ff[47:41]};
      five_prod  = {8'd0, five_part} * 18'd205;
      five_digit = five_prod[16:10];
      five_back  = {3'd0, five_digit} * 10'd5;
      busy_in    = busy_ff;
      mode_in    = mode_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      sh_in      = sh_ff;
      quot_in    = quot_ff;
      dsr_in     = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         mode_in = mode;
         quot_in = '0;
         dsr_in  = divisor;
         unique case (mode)
            DIV_FIVE: begin
               // The dividend is narrow here: 35 bits go through in five steps of seven.
               rem_in = '0;
               sh_in  = {dividend[34:0], 13'd0};
               cnt_in = 6'd5;
            end
            DIV_UNIT: begin
               // The quotient is known to be below 2^18, so the top bits start as remainder.
               rem_in = {2'd0, dividend[47:18]};
               sh_in  = {dividend[17:0], 30'd0};
               cnt_in = 6'd18;
            end
            default: begin
               rem_in = '0;
               sh_in  = '0;
               cnt_in = '0;
            end
         endcase
      end else if (busy_ff) begin
         if (mode_ff == DIV_FIVE) begin
            rem_in  = {29'd0, 3'(five_part - five_back)};
            sh_in   = {sh_ff[40:0], 7'd0};
            quot_in = {quot_ff[26:0], five_digit};
         end else begin
            rem_in  = fits ? 32'(trial - {1'b0, dsr_ff}) : trial[31:0];
            sh_in   = {sh_ff[46:0], 1'b0};
            quot_in = {quot_ff[32:0], fits};
         end
         cnt_in  = cnt_ff - 6'd1;
         busy_in = cnt_ff != 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      mode_ff <= mode_in;
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      quot_ff <= quot_in;
      dsr_ff  <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

// ===== src/asc_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
module asc_isqrt
   import asc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        busy,
   output logic [31:0] root
);

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [35:0] rem_ff, rem_in;
   logic [63:0] sh_ff, sh_in;
   logic [31:0] root_ff, root_in;
   logic [35:0] shifted;
   logic [35:0] trial;
   logic        fits;

   always_comb begin
      shifted = {rem_ff[33:0], sh_ff[63:62]};
      trial   = {2'd0, root_ff, 2'b01};
      fits    = shifted >= trial;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd32;
         rem_in  = '0;
         sh_in   = radicand;
         root_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? shifted - trial : shifted;
         root_in = {root_ff[30:0], fits};
         sh_in   = {sh_ff[61:0], 2'b00};
         cnt_in  = cnt_ff - 6'd1;
         busy_in = cnt_ff != 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

// ===== src/asc_datapath.sv =====
// Datapath: configuration, filter state, shared multiplier, divider, root unit and output register.
module asc_datapath
   import asc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   input  logic [79:0]              req_tdata,
   input  logic                     csr_valid,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [159:0]             rsp_tdata
);

   // Configuration.
   logic        [15:0] scale_ff;
   logic signed [20:0] offset_ff [3];
   logic        [17:0] gain_ff   [3];

   // Request and filter state.
   logic signed [15:0] raw_ff  [3];
   logic signed [31:0] acc_ff  [3];
   logic signed [31:0] acc_in;
   logic        [31:0] last_time_ff;
   logic        [31:0] elapsed_ff;

   // Working registers.
   logic signed [57:0] prod_ff, prod_in;
   logic signed [24:0] s_ff, s_in;
   logic signed [33:0] v_ff, v_in;
   logic signed [33:0] f_ff, f_in;
   logic signed [31:0] y_ff, y_in;
   logic signed [23:0] a_ff    [3];
   logic signed [23:0] a_in;
   logic        [47:0] sq_ff, sq_in;
   logic signed [17:0] unit_ff [3];
   logic signed [17:0] unit_in;

   // Output register.
   logic         rsp_valid_ff;
   logic [159:0] rsp_data_ff;

   logic [1:0]         ax;
   logic signed [32:0] mul_a;
   logic signed [24:0] mul_b;
   logic signed [32:0] sc_sum;
   logic signed [34:0] diff;
   logic signed [57:0] g_shift;
   logic               v_neg;
   logic               a_neg;
   logic [23:0]        a_mag;
   logic [17:0]        q_lim;

   logic         div_start;
   div_mode_type div_mode;
   logic [47:0]  div_dividend;
   logic [31:0]  div_divisor;
   logic         div_busy;
   logic [33:0]  div_quot;
   logic         sqrt_start;
   logic         sqrt_busy;
   logic [31:0]  sqrt_root;

   assign ax = cmd.axis;

   always_comb begin
      unique case (cmd.op)
         OP_MUL_RAW: begin
            mul_a = 33'(raw_ff[ax]);
            mul_b = $signed({9'd0, scale_ff});
         end
         OP_MUL_GAIN: begin
            mul_a = 33'(y_ff);
            mul_b = $signed({7'd0, gain_ff[ax]});
         end
         OP_MUL_SQ: begin
            mul_a = 33'(a_ff[ax]);
            mul_b = 25'(a_ff[ax]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = 58'(mul_a) * 58'(mul_b);
   end

   always_comb begin
      // Scale with rounding, then negate so the vector points along gravity.
      sc_sum = $signed(prod_ff[32:0]) + 33'sd128;
      s_in   = -25'(sc_sum >>> 8);
      v_in   = 34'(acc_ff[ax]) + 34'(s_ff);
      v_neg  = v_ff[33];
      f_in   = v_neg ? -$signed(div_quot) : $signed(div_quot);

      // Leaky accumulator keeps what the output did not take, saturated to 32 bits.
      diff = 35'(v_ff) - 35'(f_ff);
      if (diff > 35'sd2147483647) begin
         acc_in = 32'sh7FFFFFFF;
      end else if (diff < -35'sd2147483648) begin
         acc_in = 32'sh80000000;
      end else begin
         acc_in = diff[31:0];
      end
      y_in = f_ff[31:0] + 32'(offset_ff[ax]);

      g_shift = (prod_ff + 58'sd32768) >>> 16;
      if (g_shift > 58'sd8388607) begin
         a_in = 24'sh7FFFFF;
      end else if (g_shift < -58'sd8388608) begin
         a_in = 24'sh800000;
      end else begin
         a_in = g_shift[23:0];
      end

      sq_in = sq_ff + prod_ff[47:0];

      a_neg   = a_ff[ax][23];
      a_mag   = a_neg ? 24'(-a_ff[ax]) : a_ff[ax];
      q_lim   = (div_quot > 34'd65536) ? 18'd65536 : div_quot[17:0];
      unit_in = a_neg ? -$signed(q_lim) : $signed(q_lim);
   end

   always_comb begin
      div_start    = (cmd.op == OP_DIV5) || (cmd.op == OP_DIVU);
      div_mode     = (cmd.op == OP_DIVU) ? DIV_UNIT : DIV_FIVE;
      if (cmd.op == OP_DIVU) begin
         div_dividend = {1'b0, a_mag, 23'd0} + {17'd0, sqrt_root[31:1]};
         div_divisor  = sqrt_root;
      end else begin
         // Magnitude plus two gives rounding to nearest with ties away from zero.
         div_dividend = {14'd0, (v_neg ? ~v_ff : v_ff) + (v_neg ? 34'd3 : 34'd2)};
         div_divisor  = 32'd5;
      end
      sqrt_start = cmd.op == OP_SQRT;
   end

   asc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .mode     (div_mode),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   asc_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({2'd0, sq_ff, 14'd0}),
      .busy     (sqrt_busy),
      .root     (sqrt_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= SCALE_RESET;
         last_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            offset_ff[i] <= '0;
            gain_ff[i]   <= GAIN_RESET;
            acc_ff[i]    <= '0;
         end
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               REG_SCALE:    scale_ff     <= csr_data[15:0];
               REG_OFFSET_X: offset_ff[0] <= $signed(csr_data);
               REG_OFFSET_Y: offset_ff[1] <= $signed(csr_data);
               REG_OFFSET_Z: offset_ff[2] <= $signed(csr_data);
               REG_GAIN_X:   gain_ff[0]   <= csr_data[17:0];
               REG_GAIN_Y:   gain_ff[1]   <= csr_data[17:0];
               REG_GAIN_Z:   gain_ff[2]   <= csr_data[17:0];
               default: ;
            endcase
         end
         if (cmd.op == OP_LOAD) begin
            last_time_ff <= req_tdata[79:48];
         end
         if (cmd.op == OP_ACC) begin
            acc_ff[ax] <= acc_in;
         end
         if (cmd.op == OP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            raw_ff[0]  <= $signed(req_tdata[15:0]);
            raw_ff[1]  <= $signed(req_tdata[31:16]);
            raw_ff[2]  <= $signed(req_tdata[47:32]);
            elapsed_ff <= req_tdata[79:48] - last_time_ff;
            sq_ff      <= '0;
            for (int i = 0; i < 3; i++) begin
               unit_ff[i] <= '0;
            end
         end
         OP_MUL_RAW, OP_MUL_GAIN, OP_MUL_SQ: prod_ff <= prod_in;
         OP_SCALE:  s_ff        <= s_in;
         OP_ADDV:   v_ff        <= v_in;
         OP_FILT:   f_ff        <= f_in;
         OP_ACC:    y_ff        <= y_in;
         OP_SAT:    a_ff[ax]    <= a_in;
         OP_SUM_SQ: sq_ff       <= sq_in;
         OP_UNIT:   unit_ff[ax] <= unit_in;
         OP_OUT: begin
            rsp_data_ff <= {2'd0, elapsed_ff, unit_ff[2], unit_ff[1], unit_ff[0],
                            a_ff[2], a_ff[1], a_ff[0]};
         end
         default: ;
      endcase
   end

   assign sts.div_busy  = div_busy;
   assign sts.sqrt_busy = sqrt_busy;
   assign sts.sq_zero   = sq_ff == '0;
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== src/asc_ctrl.sv =====
// Controller state machine that steps the datapath through one request.
module asc_ctrl
   import asc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [17:0] {
      ST_IDLE      = 18'b000000000000000001,
      ST_MUL_RAW   = 18'b000000000000000010,
      ST_SCALE     = 18'b000000000000000100,
      ST_ADDV      = 18'b000000000000001000,
      ST_DIV5      = 18'b000000000000010000,
      ST_DIV5_WAIT = 18'b000000000000100000,
      ST_FILT      = 18'b000000000001000000,
      ST_ACC       = 18'b000000000010000000,
      ST_MUL_GAIN  = 18'b000000000100000000,
      ST_SAT       = 18'b000000001000000000,
      ST_MUL_SQ    = 18'b000000010000000000,
      ST_SUM_SQ    = 18'b000000100000000000,
      ST_SQRT      = 18'b000001000000000000,
      ST_SQRT_WAIT = 18'b000010000000000000,
      ST_DIVU      = 18'b000100000000000000,
      ST_DIVU_WAIT = 18'b001000000000000000,
      ST_UNIT      = 18'b010000000000000000,
      ST_OUT       = 18'b100000000000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] axis_ff, axis_in;

   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      cmd.op     = OP_NONE;
      cmd.axis   = axis_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               axis_in  = '0;
               state_in = ST_MUL_RAW;
            end
         end
         ST_MUL_RAW: begin
            cmd.op   = OP_MUL_RAW;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.op   = OP_SCALE;
            state_in = ST_ADDV;
         end
         ST_ADDV: begin
            cmd.op   = OP_ADDV;
            state_in = ST_DIV5;
         end
         ST_DIV5: begin
            cmd.op   = OP_DIV5;
            state_in = ST_DIV5_WAIT;
         end
         ST_DIV5_WAIT: begin
            if (!sts.div_busy) begin
               state_in = ST_FILT;
            end
         end
         ST_FILT: begin
            cmd.op   = OP_FILT;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.op   = OP_ACC;
            state_in = ST_MUL_GAIN;
         end
         ST_MUL_GAIN: begin
            cmd.op   = OP_MUL_GAIN;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            cmd.op = OP_SAT;
            if (axis_ff == AXIS_LAST) begin
               axis_in  = '0;
               state_in = ST_MUL_SQ;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_MUL_RAW;
            end
         end
         ST_MUL_SQ: begin
            cmd.op   = OP_MUL_SQ;
            state_in = ST_SUM_SQ;
         end
         ST_SUM_SQ: begin
            cmd.op = OP_SUM_SQ;
            if (axis_ff == AXIS_LAST) begin
               axis_in  = '0;
               state_in = ST_SQRT;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_MUL_SQ;
            end
         end
         ST_SQRT: begin
            if (sts.sq_zero) begin
               state_in = ST_OUT;
            end else begin
               cmd.op   = OP_SQRT;
               state_in = ST_SQRT_WAIT;
            end
         end
         ST_SQRT_WAIT: begin
            if (!sts.sqrt_busy) begin
               state_in = ST_DIVU;
            end
         end
         ST_DIVU: begin
            cmd.op   = OP_DIVU;
            state_in = ST_DIVU_WAIT;
         end
         ST_DIVU_WAIT: begin
            if (!sts.div_busy) begin
               state_in = ST_UNIT;
            end
         end
         ST_UNIT: begin
            cmd.op = OP_UNIT;
            if (axis_ff == AXIS_LAST) begin
               state_in = ST_OUT;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_DIVU;
            end
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.op   = OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

endmodule

// ===== src/accel_sample_conditioner.sv =====
// Top level of the accelerometer sample conditioner.
// The root unit and the three unit-vector divisions dominate the time from an accepted
// request to its result; both are skipped when the corrected vector is zero.
// One request is worked on at a time; the next is taken the cycle after the result is loaded.
// Reset (synchronous, active high) restores the register defaults, clears the filter
// accumulators and the previous timestamp, and empties the output register.
module accel_sample_conditioner
   import asc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Input requests.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [79:0]              req_tdata,   // raw_x, raw_y, raw_z, sample_time
   // Results.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [159:0]             rsp_tdata,   // accel_x, accel_y, accel_z, unit_x,
                                                 // unit_y, unit_z, elapsed_ticks, zero pad
   // Register writes.
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   cmd_type cmd;
   sts_type sts;

   // Register writes are always taken; the user must make them only while idle (not enforced).
   assign csr_ready = 1'b1;

   // The controller sequences every request through the shared multiplier, the divider
   // and, for a nonzero vector, the root unit; the datapath holds all arithmetic and the result
   // register, so a new request can be taken while the last result still waits to be collected.
   asc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   asc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
